/* hdl/oal_pkg.sv */
// Package for the ordered array list engine: sizes, operation and status codes,
// and the control word that the top level broadcasts to the row of cells.
// No dependencies.
package oal_pkg;

	// storage size; a multiple of GROUP_SZ when above eight
	localparam int CAPACITY = 128;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;
	localparam int CFG_W    = 8;
	localparam int POS_W    = 8;
	localparam int FIDX_W   = 7;
	localparam int CMP_W    = 16;

	// priority search is split into groups of match flags
	localparam int GROUP_SZ = (CAPACITY < 8) ? CAPACITY : 8;
	localparam int NGROUPS  = CAPACITY / GROUP_SZ;
	localparam int LIDX_W   = $clog2(GROUP_SZ);

	typedef enum logic [1:0] {
		MODE_APPEND = 2'd0,
		MODE_INSERT = 2'd1,
		MODE_SEARCH = 2'd2,
		MODE_REMOVE = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_BADPOS = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	// word broadcast to every cell in the accept cycle
	typedef struct packed {
		logic               ins;
		logic               srch;
		logic [IDX_W-1:0]   pos;
		logic [CNT_W-1:0]   count;
		logic [DATA_W-1:0]  value;
	} cell_ctrl_t;

	// first hit inside one group of match flags
	typedef struct packed {
		logic              hit;
		logic [LIDX_W-1:0] lidx;
	} grp_hit_t;

endpackage

/* hdl/ordered_array_list_engine_core.sv */
// Top level of the ordered array list engine: command decode, count register,
// row of oal_cell, group encoders and result stage. Depends on oal_pkg,
// oal_cell and oal_group_enc.
//
//  channel   handshake              payload
//  command   start / busy           mode, position, item_value
//  result    done (one cycle)       status, found, found_index, entry_count
//  config    cfg_we                 cfg_wdata (max_entries)
//
// A command is taken when start is high and busy low; busy stays high for the
// cycle after, so no command is taken back to back. The result strobe rises
// behind three register stages: cell update and compare at the accepting
// edge, group priority encode, then final encode into the output register.
// Reset clears the count, the pipeline valids and sets max_entries to 128;
// entries are not cleared. The receiver cannot stall the result.
module ordered_array_list_engine_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   mode,
	input  logic [oal_pkg::POS_W-1:0]    position,
	input  logic signed [31:0]           item_value,
	input  logic                         cfg_we,
	input  logic [oal_pkg::CFG_W-1:0]    cfg_wdata,
	output logic                         done,
	output logic [1:0]                   status,
	output logic                         found,
	output logic [oal_pkg::FIDX_W-1:0]   found_index,
	output logic [7:0]                   entry_count
);

	logic                               acc;
	logic [oal_pkg::CFG_W-1:0]          max_q;
	logic [oal_pkg::CNT_W-1:0]          count_q;
	logic [oal_pkg::CNT_W-1:0]          count_d;
	logic [oal_pkg::CMP_W-1:0]          lim;
	logic                               full;
	oal_pkg::status_t                   st_d;
	oal_pkg::cell_ctrl_t                ctrl;

	logic                               valid_s1, valid_s2;
	oal_pkg::status_t                   status_s1, status_s2;
	logic                               srch_s1, srch_s2;
	logic [oal_pkg::CNT_W-1:0]          cnt_s1, cnt_s2;

	logic [oal_pkg::DATA_W-1:0]         entry_w [oal_pkg::CAPACITY];
	logic [oal_pkg::CAPACITY-1:0]       match_w;
	oal_pkg::grp_hit_t                  grp_w [oal_pkg::NGROUPS];

	logic                               hit_d;
	logic [oal_pkg::IDX_W-1:0]          idx_d;

	logic                               done_q;
	oal_pkg::status_t                   status_q;
	logic                               found_q;
	logic [oal_pkg::FIDX_W-1:0]         fidx_q;
	logic [7:0]                         ecount_q;

	assign busy = valid_s1;
	assign acc  = start && !busy;

	// clamp the capacity in use to the storage size
	always_comb begin
		if (oal_pkg::CMP_W'(max_q) >= oal_pkg::CMP_W'(oal_pkg::CAPACITY)) begin
			lim = oal_pkg::CMP_W'(oal_pkg::CAPACITY);
		end else begin
			lim = oal_pkg::CMP_W'(max_q);
		end
	end
	assign full = oal_pkg::CMP_W'(count_q) >= lim;

	// decode the command into a cell control word, status and next count
	always_comb begin
		st_d       = oal_pkg::ST_OK;
		count_d    = count_q;
		ctrl.ins   = 1'b0;
		ctrl.srch  = 1'b0;
		ctrl.pos   = oal_pkg::IDX_W'(count_q);
		ctrl.count = count_q;
		ctrl.value = item_value;
		case (oal_pkg::mode_t'(mode))
			oal_pkg::MODE_APPEND: begin
				if (full) begin
					st_d = oal_pkg::ST_FULL;
				end else begin
					ctrl.ins = acc;
					count_d  = count_q + 1'b1;
				end
			end
			oal_pkg::MODE_INSERT: begin
				if (full) begin
					st_d = oal_pkg::ST_FULL;
				end else if (oal_pkg::CMP_W'(position) > oal_pkg::CMP_W'(count_q)) begin
					st_d = oal_pkg::ST_BADPOS;
				end else begin
					ctrl.ins = acc;
					ctrl.pos = oal_pkg::IDX_W'(position);
					count_d  = count_q + 1'b1;
				end
			end
			oal_pkg::MODE_SEARCH: begin
				if (count_q == '0) begin
					st_d = oal_pkg::ST_EMPTY;
				end else begin
					ctrl.srch = acc;
				end
			end
			oal_pkg::MODE_REMOVE: begin
				if (count_q == '0) begin
					st_d = oal_pkg::ST_EMPTY;
				end else begin
					count_d = count_q - 1'b1;
				end
			end
			default: begin
				st_d = oal_pkg::ST_OK;
			end
		endcase
	end

	// hold the capacity register and the live count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q   <= oal_pkg::CFG_W'(128);
			count_q <= '0;
		end else begin
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
			if (acc) begin
				count_q <= count_d;
			end
		end
	end

	// row of cells, each above the first fed by its lower neighbour
	for (genvar i = 0; i < oal_pkg::CAPACITY; i++) begin : g_cell
		oal_cell u_cell (
			.clk        (clk),
			.idx        (oal_pkg::IDX_W'(i)),
			.ctrl       (ctrl),
			.prev_entry ((i == 0) ? item_value : entry_w[(i == 0) ? 0 : i - 1]),
			.entry      (entry_w[i]),
			.match      (match_w[i])
		);
	end

	// first-level priority encode per group
	for (genvar g = 0; g < oal_pkg::NGROUPS; g++) begin : g_grp
		oal_group_enc u_grp (
			.clk   (clk),
			.flags (match_w[g*oal_pkg::GROUP_SZ +: oal_pkg::GROUP_SZ]),
			.hit   (grp_w[g])
		);
	end

	// advance the command's control word alongside the search stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= acc;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		status_s1 <= st_d;
		srch_s1   <= (oal_pkg::mode_t'(mode) == oal_pkg::MODE_SEARCH) && (st_d == oal_pkg::ST_OK);
		cnt_s1    <= count_d;
		status_s2 <= status_s1;
		srch_s2   <= srch_s1;
		cnt_s2    <= cnt_s1;
	end

	// pick the lowest group with a hit
	always_comb begin
		hit_d = 1'b0;
		idx_d = '0;
		for (int g = oal_pkg::NGROUPS - 1; g >= 0; g--) begin
			if (grp_w[g].hit) begin
				hit_d = 1'b1;
				idx_d = oal_pkg::IDX_W'(g * oal_pkg::GROUP_SZ) |
				        oal_pkg::IDX_W'(grp_w[g].lidx);
			end
		end
	end

	// result register: one-cycle strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		status_q <= status_s2;
		ecount_q <= 8'(cnt_s2);
		if (srch_s2 && hit_d) begin
			found_q <= 1'b1;
			fidx_q  <= oal_pkg::FIDX_W'(32'(idx_d));
		end else begin
			found_q <= 1'b0;
			fidx_q  <= '0;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign found       = found_q;
	assign found_index = fidx_q;
	assign entry_count = ecount_q;

endmodule

/* hdl/oal_cell.sv */
// One storage cell of the list: holds an entry, shifts from its lower
// neighbour on insert and flags a search match. Depends on oal_pkg.
module oal_cell (
	input  logic                        clk,
	input  logic [oal_pkg::IDX_W-1:0]   idx,
	input  oal_pkg::cell_ctrl_t         ctrl,
	input  logic [oal_pkg::DATA_W-1:0]  prev_entry,
	output logic [oal_pkg::DATA_W-1:0]  entry,
	output logic                        match
);

	logic [oal_pkg::DATA_W-1:0] entry_q;
	logic                       match_q;
	logic [oal_pkg::CNT_W-1:0]  idx_w;

	assign idx_w = oal_pkg::CNT_W'(idx);

	// load the new word at the insert point, take the neighbour's word above it
	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (idx == ctrl.pos) begin
				entry_q <= ctrl.value;
			end else if ((idx > ctrl.pos) && (idx_w <= ctrl.count)) begin
				entry_q <= prev_entry;
			end
		end
	end

	// compare live entries against the searched word
	always_ff @(posedge clk) begin
		match_q <= ctrl.srch && (idx_w < ctrl.count) && (entry_q == ctrl.value);
	end

	assign entry = entry_q;
	assign match = match_q;

endmodule

/* hdl/oal_group_enc.sv */
// Registered priority encoder over one group of cell match flags: lowest
// set flag wins. Depends on oal_pkg.
module oal_group_enc (
	input  logic                          clk,
	input  logic [oal_pkg::GROUP_SZ-1:0]  flags,
	output oal_pkg::grp_hit_t             hit
);

	oal_pkg::grp_hit_t hit_d;
	oal_pkg::grp_hit_t hit_q;

	// scan from the top so the lowest flag is kept
	always_comb begin
		hit_d.hit  = 1'b0;
		hit_d.lidx = '0;
		for (int i = oal_pkg::GROUP_SZ - 1; i >= 0; i--) begin
			if (flags[i]) begin
				hit_d.hit  = 1'b1;
				hit_d.lidx = oal_pkg::LIDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		hit_q <= hit_d;
	end

	assign hit = hit_q;

endmodule

/* tb/testbench.sv */
// Self-checking bench for ordered_array_list_engine_core: a queued command driver,
// a result monitor and a list model that mirrors the store and the count.
// Depends on oal_pkg and the engine RTL.
`timescale 1ns / 100ps

module testbench;
	import oal_pkg::*;

	localparam int SETTLE_CYC     = 6;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int PHASE_WORDS    = 210;
	localparam int NUM_PHASES     = 8;

	// one queued word: either a command or a capacity write
	typedef struct {
		bit                 is_cfg;
		logic [CFG_W-1:0]   cfg_val;
		mode_t              op;
		logic [POS_W-1:0]   pos;
		logic signed [31:0] val;
	} list_word_t;

	typedef struct {
		status_t            status;
		logic               found;
		logic [FIDX_W-1:0]  fidx;
		logic [7:0]         count;
	} list_result_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       start = 1'b0;
	logic                       busy;
	logic [1:0]                 mode = MODE_APPEND;
	logic [POS_W-1:0]           position = '0;
	logic signed [31:0]         item_value = '0;
	logic                       cfg_we = 1'b0;
	logic [CFG_W-1:0]           cfg_wdata = 8'd128;
	logic                       done;
	logic [1:0]                 status;
	logic                       found;
	logic [FIDX_W-1:0]          found_index;
	logic [7:0]                 entry_count;

	list_word_t                 list_cmds[$];
	list_result_t               due_results[$];

	// model of the list
	logic signed [31:0]         list_mem[CAPACITY];
	int                         list_count = 0;
	int                         cap_limit = CAPACITY;

	// stimulus generation mirror of the count
	int                         gen_count = 0;
	int                         gen_limit = CAPACITY;
	logic signed [31:0]         val_pool[16];

	// driver and monitor state
	int                         gap_left;
	int                         burst_left;
	int                         settle_cyc;
	logic                       nxt_start;
	logic                       nxt_cfg_we;
	int                         quiet_cycles = 0;
	int                         errors = 0;
	int                         n_words = 0;
	int                         n_cfg = 0;
	int                         n_full = 0;
	int                         n_badpos = 0;
	int                         n_empty = 0;
	int                         n_hits = 0;
	int                         peak_count = 0;
	list_result_t               want;

	ordered_array_list_engine_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.mode        (mode),
		.position    (position),
		.item_value  (item_value),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.done        (done),
		.status      (status),
		.found       (found),
		.found_index (found_index),
		.entry_count (entry_count)
	);

	always #1 clk = ~clk;

	// apply one accepted command to the model and return its result
	function automatic list_result_t apply_list_op(mode_t op, logic [POS_W-1:0] pos,
			logic signed [31:0] val);
		list_result_t r;
		logic is_full;
		int i;
		r.status = ST_OK;
		r.found  = 1'b0;
		r.fidx   = '0;
		is_full  = (list_count >= cap_limit);
		case (op)
		MODE_APPEND: begin
			if (is_full)
				r.status = ST_FULL;
			else begin
				list_mem[list_count] = val;
				list_count++;
			end
		end
		MODE_INSERT: begin
			if (is_full)
				r.status = ST_FULL;
			else if (int'(pos) > list_count)
				r.status = ST_BADPOS;
			else begin
				for (i = list_count; i > int'(pos); i--)
					list_mem[i] = list_mem[i-1];
				list_mem[pos] = val;
				list_count++;
			end
		end
		MODE_SEARCH: begin
			if (list_count == 0)
				r.status = ST_EMPTY;
			else begin
				for (i = 0; i < list_count; i++) begin
					if (!r.found && list_mem[i] == val) begin
						r.found = 1'b1;
						r.fidx  = FIDX_W'(i);
					end
				end
			end
		end
		default: begin
			if (list_count == 0)
				r.status = ST_EMPTY;
			else
				list_count--;
		end
		endcase
		r.count = 8'(list_count);
		n_words++;
		if (r.status == ST_FULL) n_full++;
		if (r.status == ST_BADPOS) n_badpos++;
		if (r.status == ST_EMPTY) n_empty++;
		if (r.found) n_hits++;
		if (list_count > peak_count) peak_count = list_count;
		return r;
	endfunction

	// mostly short gaps, a few long ones, and stretches with none at all
	function automatic int draw_gap();
		int r;
		r = $urandom_range(99);
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if (r < 3)
			burst_left = $urandom_range(20, 60);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// queue a command and track the count it leaves behind
	task automatic add_cmd(mode_t op, int pos, logic signed [31:0] val);
		list_word_t w;
		w.is_cfg  = 1'b0;
		w.cfg_val = '0;
		w.op      = op;
		w.pos     = POS_W'(pos);
		w.val     = val;
		list_cmds.push_back(w);
		case (op)
		MODE_APPEND: if (gen_count < gen_limit) gen_count++;
		MODE_INSERT: if (gen_count < gen_limit && pos <= gen_count) gen_count++;
		MODE_REMOVE: if (gen_count > 0) gen_count--;
		default: ;
		endcase
	endtask

	task automatic add_cfg(int v);
		list_word_t w;
		w.is_cfg  = 1'b1;
		w.cfg_val = CFG_W'(v);
		w.op      = MODE_APPEND;
		w.pos     = '0;
		w.val     = '0;
		list_cmds.push_back(w);
		gen_limit = (v > CAPACITY) ? CAPACITY : v;
	endtask

	// driver: hold the current word until taken, insert gaps, write capacity when idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start      <= 1'b0;
			mode       <= MODE_APPEND;
			position   <= '0;
			item_value <= '0;
			cfg_we     <= 1'b0;
			cfg_wdata  <= 8'd128;
			gap_left   = 0;
			burst_left = 0;
			settle_cyc = 0;
		end else begin
			nxt_start  = 1'b0;
			nxt_cfg_we = 1'b0;
			if (start && !busy) begin
				due_results.push_back(apply_list_op(list_cmds[0].op, list_cmds[0].pos,
					list_cmds[0].val));
				list_cmds.pop_front();
				gap_left = draw_gap();
			end
			if (due_results.size() == 0 && !start)
				settle_cyc++;
			else
				settle_cyc = 0;

			if (start && busy)
				nxt_start = 1'b1;
			else if (gap_left > 0)
				gap_left--;
			else if (list_cmds.size() != 0) begin
				if (list_cmds[0].is_cfg) begin
					if (settle_cyc >= SETTLE_CYC && !cfg_we) begin
						nxt_cfg_we = 1'b1;
						cfg_wdata  <= list_cmds[0].cfg_val;
						cap_limit  = (int'(list_cmds[0].cfg_val) > CAPACITY) ?
							CAPACITY : int'(list_cmds[0].cfg_val);
						n_cfg++;
						list_cmds.pop_front();
					end
				end else begin
					nxt_start = 1'b1;
					mode       <= list_cmds[0].op;
					position   <= list_cmds[0].pos;
					item_value <= list_cmds[0].val;
				end
			end
			start  <= nxt_start;
			cfg_we <= nxt_cfg_we;
		end
	end

	task automatic flag_mismatch(string field, int exp_v, int act_v);
		errors++;
		$display("%0t: %s mismatch: expected %0d, got %0d", $time, field, exp_v, act_v);
	endtask

	// monitor: check each result word against the oldest prediction; watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (due_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result word: status %0d count %0d",
						$time, status, entry_count);
				end else begin
					want = due_results.pop_front();
					if (status !== want.status)
						flag_mismatch("status", want.status, status);
					if (found !== want.found)
						flag_mismatch("found", want.found, found);
					if (found_index !== want.fidx)
						flag_mismatch("found_index", want.fidx, found_index);
					if (entry_count !== want.count)
						flag_mismatch("entry_count", want.count, entry_count);
				end
			end
			if (done || (start && !busy) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog expired, %0d words queued, %0d results due",
					$time, list_cmds.size(), due_results.size());
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// stimulus: directed corner cases, then phased random traffic
	initial begin
		int ph;
		int k;
		int r;
		int pos;
		bit fill;
		mode_t op;
		logic signed [31:0] v;
		int phase_lim[NUM_PHASES];
		bit phase_fill[NUM_PHASES];

		val_pool[0] = 32'sh8000_0000;
		val_pool[1] = 32'sh7fff_ffff;
		val_pool[2] = 32'sh0;
		val_pool[3] = -32'sd1;
		val_pool[4] = 32'sd1;
		for (k = 5; k < 16; k++)
			val_pool[k] = $urandom;

		// directed: empty list, edges of position and value, duplicates, capacity corners
		add_cfg(128);
		add_cmd(MODE_SEARCH, 0, 32'sd5);
		add_cmd(MODE_REMOVE, 0, 0);
		add_cmd(MODE_INSERT, 1, 32'sd7);
		add_cmd(MODE_INSERT, 0, 32'sh8000_0000);
		add_cmd(MODE_APPEND, 255, 32'sh7fff_ffff);
		add_cmd(MODE_APPEND, 0, 32'sh0);
		add_cmd(MODE_APPEND, 0, -32'sd1);
		add_cmd(MODE_INSERT, 1, 32'sh5555_5555);
		add_cmd(MODE_INSERT, 255, 32'shaaaa_aaaa);
		add_cmd(MODE_INSERT, 5, 32'sh0);
		add_cmd(MODE_SEARCH, 0, 32'sh0);
		add_cmd(MODE_SEARCH, 255, 32'sh7fff_ffff);
		add_cmd(MODE_SEARCH, 0, 32'sd12345);
		add_cmd(MODE_REMOVE, 0, 0);
		// capacity below the count: adds refuse, search and remove still work
		add_cfg(2);
		add_cmd(MODE_APPEND, 0, 32'sd9);
		add_cmd(MODE_INSERT, 200, 32'sd9);
		add_cmd(MODE_SEARCH, 0, -32'sd1);
		add_cmd(MODE_REMOVE, 0, 0);
		// capacity zero: always full
		add_cfg(0);
		add_cmd(MODE_INSERT, 0, 32'sd3);
		add_cmd(MODE_REMOVE, 0, 0);
		add_cmd(MODE_SEARCH, 0, 32'sh8000_0000);
		add_cfg(255);
		add_cmd(MODE_APPEND, 0, 32'sd11);

		phase_lim  = '{128, 255, 3, 0, $urandom_range(2, 127), 128, $urandom_range(1, 8), 128};
		phase_fill = '{1, 1, 0, 0, 1, 0, 1, 1};
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			add_cfg(phase_lim[ph]);
			fill = phase_fill[ph];
			for (k = 0; k < PHASE_WORDS; k++) begin
				r = $urandom_range(99);
				if (fill)
					op = (r < 35) ? MODE_APPEND : (r < 65) ? MODE_INSERT :
						(r < 90) ? MODE_SEARCH : MODE_REMOVE;
				else
					op = (r < 15) ? MODE_APPEND : (r < 30) ? MODE_INSERT :
						(r < 60) ? MODE_SEARCH : MODE_REMOVE;
				r = $urandom_range(9);
				if (op != MODE_INSERT || r == 8)
					pos = $urandom_range(255);
				else if (r == 9)
					pos = (gen_count < 255) ? gen_count + 1 : 255;
				else
					pos = $urandom_range(gen_count);
				v = ($urandom_range(9) < 6) ? val_pool[$urandom_range(15)] : $urandom;
				add_cmd(op, pos, v);
			end
		end

		// hold reset, then release it
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// drain: all words taken, all results in, then a short tail
		while (list_cmds.size() != 0 || due_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Ran %0d commands over %0d capacity writes; peak count %0d, %0d search hits",
			n_words, n_cfg, peak_count, n_hits);
		$display("Refusals seen: %0d full, %0d bad position, %0d empty",
			n_full, n_badpos, n_empty);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
